>>> rtl/core/hrsp_pkg.sv
// shared types, codes and constants for the http response stream parser
`default_nettype none

package hrsp_pkg;

  // default header size limit in bytes
  localparam int unsigned HeaderBytesDef = 512;

  // reset value of the body size limit register
  localparam logic [31:0] MaxBodyRst = 32'd1048576;

  // beat widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 96;

  // status codes
  localparam logic signed [10:0] StatusNone = -11'sd1;
  localparam logic signed [10:0] StatusOk   = 11'sd200;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_ERROR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    OC_RUN  = 2'd0,
    OC_OK   = 2'd1,
    OC_FAIL = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    RS_NONE     = 3'd0,
    RS_HDR_BIG  = 3'd1,
    RS_BODY_BIG = 3'd2,
    RS_BAD_RESP = 3'd3,
    RS_NOT_200  = 3'd4,
    RS_LINK     = 3'd5
  } reason_e;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_e;

  // header parser view handed to the control unit
  typedef struct packed {
    logic              full;
    logic              done;
    logic signed [10:0] status;
    logic              len_found;
    logic [31:0]       len_val;
  } hdr_info_t;

  // one result beat before packing
  typedef struct packed {
    logic               body_valid;
    logic [7:0]         body_byte;
    outcome_e           outcome;
    reason_e            reason;
    logic               header_complete;
    logic signed [10:0] status;
    logic               length_found;
    logic [31:0]        content_length;
    logic [31:0]        body_count;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/hrsp_in_stage.sv
// input register stage for request beats
`default_nettype none

module hrsp_in_stage (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   ready_o,
  input  wire logic [1:0]                        op_i,
  input  wire logic [hrsp_pkg::InDataW-1:0]      byte_i,
  input  wire logic                              out_ready_i,
  output logic                                   fire_o,
  output logic [1:0]                             op_o,
  output logic [hrsp_pkg::InDataW-1:0]           byte_o
);

  logic                          valid_q;
  logic                          valid_d;
  logic [1:0]                    op_q;
  logic [hrsp_pkg::InDataW-1:0]  byte_q;
  logic                          take;

  assign fire_o  = valid_q && out_ready_i;
  assign ready_o = !valid_q || out_ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fire_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= op_i;
      byte_q <= byte_i;
    end
  end

  assign op_o   = op_q;
  assign byte_o = byte_q;

endmodule

`default_nettype wire

>>> rtl/core/hrsp_hdr_parser.sv
// header byte parser: size count, blank line search, status and length extraction
`default_nettype none

module hrsp_hdr_parser #(
  parameter int unsigned HEADER_BYTES = hrsp_pkg::HeaderBytesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output hrsp_pkg::hdr_info_t   info_o
);

  localparam int unsigned HCW = $clog2(HEADER_BYTES);

  localparam logic [2:0]  SpSeek  = 3'd0;
  localparam logic [2:0]  SpFirst = 3'd1;
  localparam logic [2:0]  SpGot   = 3'd4;
  localparam logic [2:0]  SpBad   = 3'd5;
  localparam logic [1:0]  VpIdle  = 2'd0;
  localparam logic [1:0]  VpSkip  = 2'd1;
  localparam logic [1:0]  VpDigit = 2'd2;
  localparam logic [4:0]  KeyLen  = 5'd16;
  localparam logic [31:0] Term    = 32'h0D0A0D0A;
  localparam logic [7:0]  ChNl    = 8'h0A;
  localparam logic [7:0]  ChSp    = 8'h20;

  // match key, newline first
  function automatic logic [7:0] key_at(logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = ChNl;
      4'd1:    c = "C";
      4'd2:    c = "o";
      4'd3:    c = "n";
      4'd4:    c = "t";
      4'd5:    c = "e";
      4'd6:    c = "n";
      4'd7:    c = "t";
      4'd8:    c = "-";
      4'd9:    c = "L";
      4'd10:   c = "e";
      4'd11:   c = "n";
      4'd12:   c = "g";
      4'd13:   c = "t";
      4'd14:   c = "h";
      4'd15:   c = ":";
      default: c = ChNl;
    endcase
    return c;
  endfunction

  // v * 10 + d, saturating at 32 bits
  function automatic logic [31:0] acc_digit(logic [31:0] v, logic [3:0] d);
    logic [35:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {32'd0, d};
    return (t[35:32] != 4'd0) ? '1 : t[31:0];
  endfunction

  logic [HCW-1:0]     hc_q, hc_d;
  logic [31:0]        win_q, win_d;
  logic               te_q, te_d;
  logic [2:0]         sp_q, sp_d;
  logic signed [10:0] sv_q, sv_d;
  logic [4:0]         mi_q, mi_d;
  logic [1:0]         vp_q, vp_d;
  logic               sf_q, sf_d;
  logic [31:0]        sval_q, sval_d;
  logic               lf_q, lf_d;
  logic [31:0]        lv_q, lv_d;
  logic [4:0]         mi_nx;
  logic               done;
  logic               is_digit;

  assign is_digit = (byte_i >= "0") && (byte_i <= "9");

  always_comb begin
    hc_d   = hc_q;
    win_d  = win_q;
    te_d   = te_q;
    sp_d   = sp_q;
    sv_d   = sv_q;
    mi_d   = mi_q;
    vp_d   = vp_q;
    sf_d   = sf_q;
    sval_d = sval_q;
    lf_d   = lf_q;
    lv_d   = lv_q;
    mi_nx  = 5'd0;
    done   = 1'b0;
    if (step_i) begin
      hc_d  = hc_q + HCW'(1);
      win_d = {win_q[23:0], byte_i};
      if (!te_q) begin
        if (byte_i == 8'h00) begin
          // nul ends the parsed text
          te_d = 1'b1;
          if (sp_q < SpGot) begin
            sp_d = SpBad;
          end
          vp_d = VpIdle;
        end else begin
          // status code after the first space
          if (sp_q == SpSeek) begin
            if (byte_i == ChSp) begin
              sp_d = SpFirst;
              sv_d = 11'sd0;
            end
          end else if (sp_q < SpGot) begin
            if (is_digit) begin
              sv_d = 11'((sv_q << 3) + (sv_q << 1)) + {7'd0, byte_i[3:0]};
              sp_d = sp_q + 3'd1;
            end else begin
              sp_d = SpBad;
            end
          end
          // length value digits
          if (vp_q == VpSkip) begin
            if (is_digit) begin
              vp_d = VpDigit;
            end else if (byte_i != ChSp) begin
              vp_d = VpIdle;
            end
          end else if (vp_q == VpDigit && !is_digit) begin
            vp_d = VpIdle;
          end
          if (vp_d == VpDigit) begin
            if (lf_q) begin
              lv_d = acc_digit(lv_q, byte_i[3:0]);
            end else begin
              sval_d = acc_digit(sval_q, byte_i[3:0]);
            end
          end
          // key search
          if (!lf_q) begin
            if (!mi_q[4] && byte_i == key_at(mi_q[3:0])) begin
              mi_nx = mi_q + 5'd1;
            end else begin
              mi_nx = (byte_i == ChNl) ? 5'd1 : 5'd0;
            end
            if (mi_nx == KeyLen) begin
              mi_d = 5'd0;
              if (32'(hc_d) == 32'd15) begin
                // match at the very start of the header
                sf_d   = 1'b1;
                sval_d = 32'd0;
              end else begin
                lf_d = 1'b1;
                lv_d = 32'd0;
              end
              vp_d = VpSkip;
            end else begin
              mi_d = mi_nx;
            end
          end
        end
      end
      // blank line ends the header
      if (32'(hc_d) >= 32'd4 && win_d == Term) begin
        done = 1'b1;
        vp_d = VpIdle;
        if (sp_d != SpGot) begin
          sv_d = hrsp_pkg::StatusNone;
        end
        if (!lf_d && sf_d) begin
          lf_d = 1'b1;
          lv_d = sval_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q   <= '0;
      win_q  <= '0;
      te_q   <= 1'b0;
      sp_q   <= SpSeek;
      sv_q   <= hrsp_pkg::StatusNone;
      mi_q   <= 5'd1;
      vp_q   <= VpIdle;
      sf_q   <= 1'b0;
      sval_q <= '0;
      lf_q   <= 1'b0;
      lv_q   <= '0;
    end else begin
      hc_q   <= hc_d;
      win_q  <= win_d;
      te_q   <= te_d;
      sp_q   <= sp_d;
      sv_q   <= sv_d;
      mi_q   <= mi_d;
      vp_q   <= vp_d;
      sf_q   <= sf_d;
      sval_q <= sval_d;
      lf_q   <= lf_d;
      lv_q   <= lv_d;
    end
  end

  assign info_o.full      = 32'(hc_q) >= 32'(HEADER_BYTES - 1);
  assign info_o.done      = done;
  assign info_o.status    = sv_d;
  assign info_o.len_found = lf_d;
  assign info_o.len_val   = lv_d;

endmodule

`default_nettype wire

>>> rtl/core/hrsp_ctrl.sv
// phase control, body forwarding, outcome tracking and result assembly
`default_nettype none

module hrsp_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [1:0]          op_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic                cfg_we_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire hrsp_pkg::hdr_info_t info_i,
  output logic                     hdr_step_o,
  output hrsp_pkg::result_t        res_o
);

  hrsp_pkg::phase_e   phase_q, phase_d;
  hrsp_pkg::outcome_e oc_q, oc_d;
  hrsp_pkg::reason_e  rs_q, rs_d;
  logic [31:0]        cnt_q, cnt_d;
  logic [31:0]        max_q;
  logic               fwd;

  // event handling
  always_comb begin
    oc_d       = oc_q;
    rs_d       = rs_q;
    cnt_d      = cnt_q;
    fwd        = 1'b0;
    hdr_step_o = 1'b0;
    if (step_i && oc_q == hrsp_pkg::OC_RUN) begin
      unique case (op_i)
        hrsp_pkg::OP_ERROR: begin
          oc_d = hrsp_pkg::OC_FAIL;
          rs_d = hrsp_pkg::RS_LINK;
        end
        hrsp_pkg::OP_CLOSE: begin
          if (phase_q == hrsp_pkg::PH_HEADER) begin
            oc_d = hrsp_pkg::OC_FAIL;
            rs_d = hrsp_pkg::RS_BAD_RESP;
          end else if (info_i.status != hrsp_pkg::StatusOk) begin
            oc_d = hrsp_pkg::OC_FAIL;
            rs_d = hrsp_pkg::RS_NOT_200;
          end else begin
            oc_d = hrsp_pkg::OC_OK;
            rs_d = hrsp_pkg::RS_NONE;
          end
        end
        hrsp_pkg::OP_DATA: begin
          if (phase_q == hrsp_pkg::PH_HEADER) begin
            if (info_i.full) begin
              oc_d = hrsp_pkg::OC_FAIL;
              rs_d = hrsp_pkg::RS_HDR_BIG;
            end else begin
              hdr_step_o = 1'b1;
            end
          end else if (cnt_q >= max_q) begin
            oc_d = hrsp_pkg::OC_FAIL;
            rs_d = hrsp_pkg::RS_BODY_BIG;
          end else begin
            fwd   = 1'b1;
            cnt_d = cnt_q + 32'd1;
            if (info_i.len_found && cnt_d >= info_i.len_val) begin
              oc_d = hrsp_pkg::OC_OK;
              rs_d = hrsp_pkg::RS_NONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // phase next state
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      hrsp_pkg::PH_HEADER: begin
        if (hdr_step_o && info_i.done) begin
          phase_d = hrsp_pkg::PH_BODY;
        end
      end
      hrsp_pkg::PH_BODY: begin
        phase_d = hrsp_pkg::PH_BODY;
      end
      default: begin
        phase_d = hrsp_pkg::PH_HEADER;
      end
    endcase
  end

  // result fields
  always_comb begin
    res_o.body_valid      = fwd;
    res_o.body_byte       = fwd ? byte_i : 8'd0;
    res_o.outcome         = oc_d;
    res_o.reason          = rs_d;
    res_o.header_complete = hdr_step_o && info_i.done;
    res_o.status          = (phase_d == hrsp_pkg::PH_HEADER) ? hrsp_pkg::StatusNone
                                                            : info_i.status;
    res_o.length_found    = (phase_d == hrsp_pkg::PH_BODY) && info_i.len_found;
    res_o.content_length  = res_o.length_found ? info_i.len_val : 32'd0;
    res_o.body_count      = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrsp_pkg::PH_HEADER;
      oc_q    <= hrsp_pkg::OC_RUN;
      rs_q    <= hrsp_pkg::RS_NONE;
      cnt_q   <= '0;
      max_q   <= hrsp_pkg::MaxBodyRst;
    end else begin
      phase_q <= phase_d;
      oc_q    <= oc_d;
      rs_q    <= rs_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hrsp_out_stage.sv
// result register stage, packs one result beat
`default_nettype none

module hrsp_out_stage (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire hrsp_pkg::result_t             res_i,
  output logic                               ready_o,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [hrsp_pkg::OutDataW-1:0]      data_o,
  output logic                               user_o
);

  logic                              valid_q, valid_d;
  logic [hrsp_pkg::OutDataW-1:0]     data_q;
  logic                              user_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      user_q <= res_i.body_valid;
      data_q <= {6'd0, res_i.body_count, res_i.content_length, res_i.length_found,
                 res_i.status, res_i.header_complete, res_i.reason, res_i.outcome,
                 res_i.body_byte};
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign user_o  = user_q;

endmodule

`default_nettype wire

>>> rtl/core/http_response_stream_parser.sv
// http response stream parser: an input beat goes through the input register, then
// the result register; throughput one beat per cycle while m_axis_tready is high, one
// result beat per input beat, set by the input and result registers each turning over
// once a cycle; s_axis_tready follows m_axis_tready combinationally through both stages
// reset clears phase, counters, parser state and outcome and loads the body limit
`default_nettype none

module http_response_stream_parser #(
  parameter int unsigned HEADER_BYTES = hrsp_pkg::HeaderBytesDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request beats
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [hrsp_pkg::InDataW-1:0]    s_axis_tdata,  // [7:0] data_byte
  input  wire logic [1:0]                      s_axis_tuser,  // [1:0] opcode
  // result beats
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] body_byte, [9:8] outcome, [12:10] fail_reason, [13] header_complete,
  // [24:14] resp_status, [25] length_found, [57:26] content_length,
  // [89:58] body_count, [95:90] zero
  output logic [hrsp_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                 m_axis_tuser,  // [0] body_valid
  // body size limit register
  input  wire logic                            cfg_we_i,
  input  wire logic [31:0]                     cfg_wdata_i
);

  logic                 out_ready;
  logic                 fire;
  logic [1:0]           op;
  logic [7:0]           data_byte;
  logic                 hdr_step;
  hrsp_pkg::hdr_info_t  hdr_info;
  hrsp_pkg::result_t    res;

  // input register, moves forward whenever the result register can take a beat
  hrsp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .op_i       (s_axis_tuser),
    .byte_i     (s_axis_tdata),
    .out_ready_i(out_ready),
    .fire_o     (fire),
    .op_o       (op),
    .byte_o     (data_byte)
  );

  // header side: byte count, terminator window, status and length extraction
  hrsp_hdr_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_hdr (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(hdr_step),
    .byte_i(data_byte),
    .info_o(hdr_info)
  );

  // phase, body count, outcome; builds the result of the beat in flight
  hrsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (fire),
    .op_i       (op),
    .byte_i     (data_byte),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .info_i     (hdr_info),
    .hdr_step_o (hdr_step),
    .res_o      (res)
  );

  // result register, a finished beat waits here while the next one is worked on
  hrsp_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .res_i  (res),
    .ready_o(out_ready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .data_o (m_axis_tdata),
    .user_o (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> verif/http_response_stream_parser_tb.sv
// self-checking testbench for the http response stream parser: one long response, byte by byte
module http_response_stream_parser_tb;
  import hrsp_pkg::*;

  // opcode value the block has no use for, must be ignored
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharSp = 8'h20;
  localparam logic [7:0] CharNul = 8'h00;

  // key searched in the header, a newline ahead of the field name
  localparam logic [127:0] LengthKey = {CharLf, "Content-Length:"};
  localparam int unsigned KeyLen = 16;
  localparam int unsigned HdrLimit = HeaderBytesDef;

  // status digit parser states
  localparam logic [2:0] StSeekSpace = 3'd0;
  localparam logic [2:0] StComplete = 3'd4;
  localparam logic [2:0] StMalformed = 3'd5;

  // content length value states
  localparam logic [1:0] ValIdle = 2'd0;
  localparam logic [1:0] ValSpaces = 2'd1;
  localparam logic [1:0] ValDigits = 2'd2;

  localparam int unsigned DrainCycles = 6;
  localparam int unsigned LongHold = 150;
  localparam longint CycleLimit = 1000000;

  // result of a beat while the header is still running, or after reset
  localparam result_t HeaderIdle = '{
    body_valid: 1'b0, body_byte: 8'h00, outcome: OC_RUN, reason: RS_NONE,
    header_complete: 1'b0, status: StatusNone, length_found: 1'b0,
    content_length: 32'd0, body_count: 32'd0
  };

  // first line of the directed part: the length field sits at the very start,
  // and its value also reads as the status code after the first space
  localparam string StartLine = "Content-Length: 200";

  typedef struct {
    logic [1:0] op;
    logic [7:0] data;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;  // [7:0] data_byte
  logic [1:0] s_axis_tuser;          // [1:0] opcode
  logic m_axis_tvalid;
  logic m_axis_tready;
  // [7:0] body_byte, [9:8] outcome, [12:10] fail_reason, [13] header_complete,
  // [24:14] resp_status, [25] length_found, [57:26] content_length,
  // [89:58] body_count, [95:90] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;                // [0] body_valid
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;

  http_response_stream_parser i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // response parser mirror: state kept beside the block, one update per beat
  // ---------------------------------------------------------------------------
  logic [31:0]        body_limit;
  phase_e             resp_phase;
  logic [9:0]         hdr_cnt;
  logic [31:0]        tail_bytes;    // last four header bytes, newest lowest
  logic [2:0]         st_phase;
  logic signed [10:0] st_val;
  logic [4:0]         key_pos;
  logic [1:0]         val_phase;
  logic               start_found;
  logic [31:0]        start_len;
  logic               line_found;
  logic [31:0]        line_len;
  logic               text_done;     // a nul byte ended the parsed header text
  logic [31:0]        body_cnt;
  outcome_e           job_outcome;
  reason_e            job_reason;

  result_t pending_results[$];

  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned beats_sent;
  bit          send_burst;
  bit          recv_burst;
  int unsigned hold_left;
  int unsigned sink_cycles;
  bit          long_hold_done;
  longint      cycle_cnt;

  function automatic void reset_parser_mirror();
    body_limit  = MaxBodyRst;
    resp_phase  = PH_HEADER;
    hdr_cnt     = '0;
    tail_bytes  = '0;
    st_phase    = StSeekSpace;
    st_val      = StatusNone;
    key_pos     = 5'd1;          // as if a newline came before the header
    val_phase   = ValIdle;
    start_found = 1'b0;
    start_len   = '0;
    line_found  = 1'b0;
    line_len    = '0;
    text_done   = 1'b0;
    body_cnt    = '0;
    job_outcome = OC_RUN;
    job_reason  = RS_NONE;
  endfunction

  function automatic logic [7:0] key_char(input logic [4:0] idx);
    return LengthKey[(KeyLen - 1 - idx) * 8 +: 8];
  endfunction

  // decimal accumulate, sticks at all ones on overflow
  function automatic logic [31:0] push_digit(input logic [31:0] v, input logic [3:0] d);
    logic [35:0] t;
    t = {4'd0, v} * 36'd10 + 36'(d);
    return (t > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  // status code, content length value and key search on one header byte
  function automatic void parse_header_byte(input logic [7:0] b);
    logic       digit;
    logic [3:0] d;
    digit = (b >= "0") && (b <= "9");
    d = b[3:0];
    if (text_done) begin
      return;
    end
    if (b == CharNul) begin
      text_done = 1'b1;
      if (st_phase < StComplete) begin
        st_phase = StMalformed;
      end
      val_phase = ValIdle;
      return;
    end
    // three digits right after the first space
    if (st_phase == StSeekSpace) begin
      if (b == CharSp) begin
        st_phase = 3'd1;
        st_val = '0;
      end
    end else if (st_phase < StComplete) begin
      if (digit) begin
        st_val = st_val * 10 + d;
        st_phase = st_phase + 3'd1;
      end else begin
        st_phase = StMalformed;
      end
    end
    // value after a matched key: skip spaces, then take digits
    if (val_phase == ValSpaces) begin
      if (digit) begin
        val_phase = ValDigits;
      end else if (b != CharSp) begin
        val_phase = ValIdle;
      end
    end else if (val_phase == ValDigits && !digit) begin
      val_phase = ValIdle;
    end
    if (val_phase == ValDigits) begin
      if (line_found) begin
        line_len = push_digit(line_len, d);
      end else begin
        start_len = push_digit(start_len, d);
      end
    end
    // search stops once a newline-led match was taken
    if (!line_found) begin
      if (key_pos < KeyLen && b == key_char(key_pos)) begin
        key_pos = key_pos + 5'd1;
      end else begin
        key_pos = (b == CharLf) ? 5'd1 : 5'd0;
      end
      if (key_pos >= KeyLen) begin
        key_pos = '0;
        // a match ending on byte 15 can only be the virtual-newline one
        if (hdr_cnt == 10'(KeyLen - 1)) begin
          start_found = 1'b1;
          start_len = '0;
        end else begin
          line_found = 1'b1;
          line_len = '0;
        end
        val_phase = ValSpaces;
      end
    end
  endfunction

  // one accepted beat in, the result beat it should produce out
  function automatic result_t predict_response_beat(input logic [1:0] op, input logic [7:0] b);
    result_t r;
    r = '0;
    if (job_outcome == OC_RUN) begin
      if (op == OP_ERROR) begin
        job_outcome = OC_FAIL;
        job_reason = RS_LINK;
      end else if (op == OP_CLOSE) begin
        job_outcome = OC_FAIL;
        if (resp_phase == PH_HEADER) begin
          job_reason = RS_BAD_RESP;
        end else if (st_val != StatusOk) begin
          job_reason = RS_NOT_200;
        end else begin
          job_outcome = OC_OK;
          job_reason = RS_NONE;
        end
      end else if (op == OP_DATA) begin
        if (resp_phase == PH_HEADER) begin
          if (int'(hdr_cnt) + 1 >= int'(HdrLimit)) begin
            job_outcome = OC_FAIL;
            job_reason = RS_HDR_BIG;
          end else begin
            hdr_cnt = hdr_cnt + 10'd1;
            tail_bytes = {tail_bytes[23:0], b};
            parse_header_byte(b);
            if (hdr_cnt >= 10'd4 && tail_bytes == {CharCr, CharLf, CharCr, CharLf}) begin
              resp_phase = PH_BODY;
              r.header_complete = 1'b1;
              val_phase = ValIdle;
              if (st_phase != StComplete) begin
                st_val = StatusNone;
              end
              // start-of-header match only counts without a newline-led one
              if (!line_found && start_found) begin
                line_found = 1'b1;
                line_len = start_len;
              end
            end
          end
        end else begin
          if ({1'b0, body_cnt} + 33'd1 > {1'b0, body_limit}) begin
            job_outcome = OC_FAIL;
            job_reason = RS_BODY_BIG;
          end else begin
            r.body_valid = 1'b1;
            r.body_byte = b;
            body_cnt = body_cnt + 32'd1;
            if (line_found && body_cnt >= line_len) begin
              job_outcome = OC_OK;
              job_reason = RS_NONE;
            end
          end
        end
      end
    end
    r.outcome = job_outcome;
    r.reason = job_reason;
    r.status = (resp_phase == PH_HEADER) ? StatusNone : st_val;
    r.length_found = (resp_phase == PH_BODY) && line_found;
    r.content_length = r.length_found ? line_len : 32'd0;
    r.body_count = body_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    if (burst) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random ready, one long hold once the body is well under way
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    sink_cycles = sink_cycles + 1;
    if (sink_cycles % 128 == 0) begin
      recv_burst = ($urandom_range(0, 3) == 0);
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!long_hold_done && results_seen >= 1000) begin
      // sender keeps offering; the pipe fills and input ready drops
      long_hold_done = 1'b1;
      hold_left = LongHold;
      m_axis_tready <= 1'b0;
    end else if (recv_burst || $urandom_range(0, 99) < 65) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      hold_left = pick_gap(1'b0);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result beat %0d: %s got 0x%0h want 0x%0h",
             results_seen, field, got, want);
    mismatches++;
  endtask

  // each result beat against the oldest pending prediction
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.body_valid      = m_axis_tuser;
      got.body_byte       = m_axis_tdata[7:0];
      got.outcome         = outcome_e'(m_axis_tdata[9:8]);
      got.reason          = reason_e'(m_axis_tdata[12:10]);
      got.header_complete = m_axis_tdata[13];
      got.status          = $signed(m_axis_tdata[24:14]);
      got.length_found    = m_axis_tdata[25];
      got.content_length  = m_axis_tdata[57:26];
      got.body_count      = m_axis_tdata[89:58];
      if (pending_results.size() == 0) begin
        $display("result beat %0d with no beat pending", results_seen);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.body_valid !== want.body_valid)
          report_mismatch("body_valid", got.body_valid, want.body_valid);
        if (got.body_byte !== want.body_byte)
          report_mismatch("body_byte", got.body_byte, want.body_byte);
        if (got.outcome !== want.outcome)
          report_mismatch("outcome", got.outcome, want.outcome);
        if (got.reason !== want.reason)
          report_mismatch("fail_reason", got.reason, want.reason);
        if (got.header_complete !== want.header_complete)
          report_mismatch("header_complete", got.header_complete, want.header_complete);
        if (got.status !== want.status)
          report_mismatch("resp_status", got.status, want.status);
        if (got.length_found !== want.length_found)
          report_mismatch("length_found", got.length_found, want.length_found);
        if (got.content_length !== want.content_length)
          report_mismatch("content_length", got.content_length, want.content_length);
        if (got.body_count !== want.body_count)
          report_mismatch("body_count", got.body_count, want.body_count);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap(send_burst);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_results.push_back(predict_response_beat(op, b));
    beats_sent++;
    if (beats_sent % 64 == 0) begin
      send_burst = ($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(OP_DATA, s[i]);
    end
  endtask

  task automatic send_crlf();
    send_beat(OP_DATA, CharCr);
    send_beat(OP_DATA, CharLf);
  endtask

  // any header byte but nul and line breaks
  function automatic logic [7:0] header_noise();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == CharCr || b == CharLf) begin
      b = 8'h7F;
    end
    return b;
  endfunction

  task automatic send_noise(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) begin
        send_beat(OpUnused, 8'($urandom_range(0, 255)));
      end
      send_beat(OP_DATA, header_noise());
    end
  endtask

  // sender pause: everything back, then the block's latency and some margin
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_body_limit(input logic [31:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    body_limit = v;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : run_response
    stim_row_t   dir_rows[23];
    bit          len_sent;
    int unsigned n;

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_DATA;
    m_axis_tready  = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    results_seen   = 0;
    mismatches     = 0;
    beats_sent     = 0;
    send_burst     = 1'b0;
    recv_burst     = 1'b0;
    hold_left      = 0;
    sink_cycles    = 0;
    long_hold_done = 1'b0;
    cycle_cnt      = 0;
    reset_parser_mirror();

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // lowest limit while the header runs; it only matters for body beats
    write_body_limit(32'd0);

    // directed part: ignored opcode straight after reset, then a first line
    // whose key sits at the very start and whose value doubles as the status
    dir_rows[0] = '{op: OpUnused, data: 8'hFF, typed: 1'b1, want: HeaderIdle};
    for (int i = 0; i < StartLine.len(); i++) begin
      dir_rows[1 + i] = '{op: OP_DATA, data: StartLine[i], typed: 1'b0, want: HeaderIdle};
    end
    dir_rows[20] = '{op: OP_DATA, data: CharCr, typed: 1'b0, want: HeaderIdle};
    dir_rows[21] = '{op: OP_DATA, data: CharLf, typed: 1'b0, want: HeaderIdle};
    dir_rows[22] = '{op: OP_DATA, data: 8'hFF, typed: 1'b1, want: HeaderIdle};
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].op, dir_rows[i].data);
      // typed rows replace the prediction just queued; the result still has to pass
      // the input and result registers, so it cannot have been popped yet
      if (dir_rows[i].typed) begin
        pending_results[pending_results.size() - 1] = dir_rows[i].want;
      end
    end
    // close the line so the first random line starts after a newline
    send_crlf();

    // random header lines, one of them a newline-led length key whose long
    // value overrides the start match and saturates
    len_sent = 1'b0;
    while (hdr_cnt < 10'd380) begin
      if (!len_sent && (hdr_cnt > 10'd250 || $urandom_range(0, 4) == 0)) begin
        send_text("Content-Length:");
        repeat ($urandom_range(0, 3)) send_beat(OP_DATA, CharSp);
        send_beat(OP_DATA, 8'("0" + $urandom_range(1, 9)));
        repeat ($urandom_range(10, 19)) send_beat(OP_DATA, 8'("0" + $urandom_range(0, 9)));
        len_sent = 1'b1;
      end else begin
        // broken key: a bare prefix of the field name, then noise
        if ($urandom_range(0, 5) == 0) begin
          n = $urandom_range(1, 14);
          for (int i = 1; i <= n; i++) begin
            send_beat(OP_DATA, key_char(5'(i)));
          end
        end
        send_noise($urandom_range(1, 24));
      end
      send_crlf();
    end

    // nul byte ends the parsed text; a later key must be ignored
    send_noise($urandom_range(1, 8));
    send_beat(OP_DATA, CharNul);
    send_noise($urandom_range(0, 8));
    send_crlf();
    send_text("Content-Length: 7");
    send_crlf();
    send_crlf();

    // body with the widest limit, some ignored beats mixed in
    write_body_limit(32'hFFFF_FFFF);
    repeat (900) begin
      send_beat(($urandom_range(0, 31) == 0) ? OpUnused : OP_DATA,
                8'($urandom_range(0, 255)));
    end

    // narrow the limit so the body runs into it
    write_body_limit(body_cnt + 32'($urandom_range(400, 700)));
    while (job_outcome == OC_RUN) begin
      send_beat(($urandom_range(0, 31) == 0) ? OpUnused : OP_DATA,
                8'($urandom_range(0, 255)));
    end

    // job is over: close, error and data must all leave the outputs alone
    send_beat(OP_CLOSE, 8'h00);
    send_beat(OP_ERROR, 8'hFF);
    repeat (22) send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));

    drain_results();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
